// ===== rtl/core/lutli_pkg.sv =====
// Shared types and constants for the lookup table linear interpolator.
// No dependencies.
package lutli_pkg;
  localparam int DataW = 32;
  localparam int CountW = 6;
  localparam int IndexW = 5;
  localparam int MaxPoints = 32;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeLookup = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [IndexW-1:0] point_index;
    logic [DataW-1:0]  axis_value;
    logic [DataW-1:0]  table_value;
    logic [DataW-1:0]  x_value;
  } item_t;
endpackage

// ===== rtl/core/lutli_front.sv =====
// Front end: accepts transactions into a two-entry queue.
// Depends on lutli_pkg.
module lutli_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lutli_pkg::item_t in_item,
  output logic             busy,
  output logic             q_valid,
  output lutli_pkg::item_t q_item,
  input  logic             q_pop
);
  import lutli_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy = (fill == 2'd2);
  assign push = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/core/lutli_back.sv =====
// Back end: breakpoint memory, top-down search, serial multiply and divide.
// Depends on lutli_pkg.
module lutli_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  lutli_pkg::item_t         q_item,
  output logic                     q_pop,
  input  logic [lutli_pkg::CountW-1:0] point_count,
  output logic                     done,
  output logic [lutli_pkg::DataW-1:0] result,
  output logic                     in_range
);
  import lutli_pkg::*;

  localparam int AW = IndexW;
  localparam int CW = $clog2(MaxPoints + 1) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPPER = 3'd3;
  localparam logic [2:0] S_MUL = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [DataW-1:0] axis_mem [MaxPoints];
  logic [DataW-1:0] table_mem [MaxPoints];
  logic [DataW-1:0] axis_rd;
  logic [DataW-1:0] table_rd;
  logic [AW-1:0]    rd_addr;
  logic             rd_wait;

  logic [2:0]       state;
  logic [CW-1:0]    n_used;
  logic [CW-1:0]    idx;
  logic [DataW-1:0] x;
  logic [DataW-1:0] x0;
  logic [DataW-1:0] y0;
  logic [DataW-1:0] mag;
  logic             neg;
  logic [DataW-1:0] span;
  logic [2*DataW-1:0] prod;
  logic [DataW-1:0] mcand;
  logic [DataW:0]   rem;
  logic [6:0]       cnt;
  logic [DataW:0]   rem_shift;
  logic [DataW:0]   rem_try;

  assign q_pop = q_valid && (state == S_IDLE);
  assign rem_shift = {rem[DataW-1:0], prod[2*DataW-1]};
  assign rem_try = rem_shift - {1'b0, span};

  always_comb begin
    if (point_count == '0) begin
      n_used = CW'(1);
    end else if (CW'(point_count) > CW'(MaxPoints)) begin
      n_used = CW'(MaxPoints);
    end else begin
      n_used = CW'(point_count);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_item.mode == ModeLoad) &&
        (32'(q_item.point_index) < 32'(MaxPoints))) begin
      axis_mem[q_item.point_index[AW-1:0]] <= q_item.axis_value;
      table_mem[q_item.point_index[AW-1:0]] <= q_item.table_value;
    end
    axis_rd <= axis_mem[rd_addr];
    table_rd <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      state <= S_IDLE;
      rd_wait <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= (state == S_OUT);
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_item.mode == ModeLookup) begin
            x <= q_item.x_value;
            rd_addr <= '0;
            rd_wait <= 1'b1;
            idx <= n_used;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          rd_wait <= 1'b0;
          if (!rd_wait) begin
            if (x <= axis_rd) begin
              result <= table_rd;
              in_range <= 1'b0;
              state <= S_OUT;
            end else begin
              rd_addr <= AW'(idx - CW'(1));
              rd_wait <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_wait <= 1'b0;
          if (!rd_wait) begin
            if (x == axis_rd) begin
              result <= table_rd;
              in_range <= 1'b1;
              state <= S_OUT;
            end else if (x > axis_rd) begin
              if (idx == n_used) begin
                result <= table_rd;
                in_range <= 1'b0;
                state <= S_OUT;
              end else begin
                x0 <= axis_rd;
                y0 <= table_rd;
                rd_addr <= AW'(idx);
                rd_wait <= 1'b1;
                state <= S_UPPER;
              end
            end else begin
              idx <= idx - CW'(1);
              rd_addr <= AW'(idx - CW'(2));
              rd_wait <= 1'b1;
            end
          end
        end
        S_UPPER: begin
          rd_wait <= 1'b0;
          if (!rd_wait) begin
            span <= axis_rd - x0;
            neg <= (table_rd < y0);
            mag <= (table_rd >= y0) ? (table_rd - y0) : (y0 - table_rd);
            mcand <= x - x0;
            prod <= '0;
            cnt <= 7'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mag[0]) begin
            prod <= prod + ({32'd0, mcand} << cnt[4:0]);
          end
          mag <= mag >> 1;
          if (cnt == 7'd31) begin
            cnt <= 7'd0;
            rem <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_DIV: begin
          if (!rem_try[DataW]) begin
            rem <= rem_try;
            prod <= {prod[2*DataW-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            prod <= {prod[2*DataW-2:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            state <= S_OUT;
            in_range <= 1'b1;
            result <= '0;
          end
        end
        S_OUT: begin
          if (in_range && (cnt == 7'd64)) begin
            result <= neg ? (y0 - prod[DataW-1:0]) : (y0 + prod[DataW-1:0]);
          end
          cnt <= 7'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/lutli_out.sv =====
// Result stage: registers the back end result and drives the strobe.
// Depends on lutli_pkg.
module lutli_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         done_in,
  input  logic [lutli_pkg::DataW-1:0]  result_in,
  input  logic                         in_range_in,
  output logic                         result_valid,
  output logic [lutli_pkg::DataW-1:0]  result,
  output logic                         in_range
);
  import lutli_pkg::*;

  always_ff @(posedge clk) begin
    result <= result_in;
    in_range <= in_range_in;
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= done_in;
    end
  end
endmodule

// ===== rtl/core/lut_linear_interpolator_top.sv =====
// Lookup table with linear interpolation over up to MaxPoints breakpoints.
// A load transaction is written to the breakpoint memory as it leaves the
// queue, and the back end stays idle. A lookup checks the lowest breakpoint,
// then searches from the top down; it finishes after the search when it clamps
// or hits a breakpoint exactly, and when it interpolates it runs 32 multiply
// and 64 divide steps in the serial multiplier and divider. The strobe is
// registered in the back end and again in the result stage. A two-entry queue
// takes transactions while the back end works. The result strobe lasts one cycle; the receiver cannot stall.
// Depends on lutli_pkg, lutli_front, lutli_back, lutli_out.
module lut_linear_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [4:0]  point_index,
  input  logic [31:0] axis_value,
  input  logic [31:0] table_value,
  input  logic [31:0] x_value,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  output logic        done,
  output logic [31:0] result,
  output logic        in_range
);
  import lutli_pkg::*;

  item_t            in_item;
  item_t            q_item;
  logic             q_valid;
  logic             q_pop;
  logic [CountW-1:0] point_count;
  logic             b_done;
  logic [DataW-1:0] b_result;
  logic             b_in_range;

  assign in_item = '{mode: mode, point_index: point_index, axis_value: axis_value,
                     table_value: table_value, x_value: x_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CountW'(1);
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  lutli_front u_front (
    .clk, .rst, .start, .in_item, .busy, .q_valid, .q_item, .q_pop
  );

  lutli_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .point_count,
    .done(b_done), .result(b_result), .in_range(b_in_range)
  );

  lutli_out u_out (
    .clk, .rst, .done_in(b_done), .result_in(b_result), .in_range_in(b_in_range),
    .result_valid(done), .result, .in_range
  );
endmodule

// ===== tb/lut_linear_interpolator_checker.sv =====
// Checker for the lookup table interpolator: watches the transaction and
// result channels, predicts each lookup result and compares it.
// Depends on lutli_pkg.
module lut_linear_interpolator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [4:0]  point_index,
  input  logic [31:0] axis_value,
  input  logic [31:0] table_value,
  input  logic [31:0] x_value,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        done,
  input  logic [31:0] result,
  input  logic        in_range,
  output int          fail_count,
  output int          pending,
  output int          lookups_seen
);
  import lutli_pkg::*;

  localparam int Points = 32;

  typedef struct packed {
    logic [31:0] y;
    logic        hit;
  } lookup_t;

  logic [31:0] curve_x [Points];
  logic [31:0] curve_y [Points];
  logic [5:0]  count_reg;
  lookup_t     expected_q [$];

  function automatic lookup_t interpolate(input logic [31:0] x);
    lookup_t     r;
    int          n;
    logic [31:0] x0, x1, y0, y1;
    logic [63:0] span, off, mag, q;
    n = (count_reg == 0) ? 1 : ((count_reg > Points) ? Points : count_reg);
    r.y = curve_y[0];
    r.hit = 1'b0;
    if (x <= curve_x[0]) return r;
    for (int i = n; i > 0; i--) begin
      if (x == curve_x[i-1]) begin
        r.y = curve_y[i-1];
        r.hit = 1'b1;
        return r;
      end
      if (x > curve_x[i-1]) begin
        if (i == n) begin
          r.y = curve_y[n-1];
          return r;
        end
        x0 = curve_x[i-1];
        x1 = curve_x[i];
        y0 = curve_y[i-1];
        y1 = curve_y[i];
        span = 64'(x1 - x0);
        off = 64'(x - x0);
        mag = (y1 >= y0) ? 64'(y1 - y0) : 64'(y0 - y1);
        q = (span != 0) ? (mag * off) / span : 64'd0;
        r.y = (y1 >= y0) ? y0 + q[31:0] : y0 - q[31:0];
        r.hit = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    lookup_t e;
    if (rst) begin
      count_reg <= 6'd1;
      for (int i = 0; i < Points; i++) begin
        curve_x[i] <= '0;
        curve_y[i] <= '0;
      end
      expected_q.delete();
      fail_count <= 0;
      lookups_seen <= 0;
    end else begin
      if (done) begin
        lookups_seen <= lookups_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h in_range %b", $time, result, in_range);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.y !== result || e.hit !== in_range) begin
            $display("%0t: mismatch expected %h/%b actual %h/%b",
                     $time, e.y, e.hit, result, in_range);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (mode == ModeLoad) begin
          curve_x[point_index] <= axis_value;
          curve_y[point_index] <= table_value;
        end else begin
          expected_q.push_back(interpolate(x_value));
        end
      end
      if (cfg_we) count_reg <= cfg_data;
    end
  end
endmodule

// ===== tb/lut_linear_interpolator_top_tb.sv =====
// Testbench top for the lookup table interpolator: drives load and lookup
// transactions under several idle patterns and gives the verdict.
// Depends on lutli_pkg, lut_linear_interpolator_top, the checker.
module lut_linear_interpolator_top_tb;
  import lutli_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = ModeLoad;
  logic [4:0]  point_index = '0;
  logic [31:0] axis_value = '0;
  logic [31:0] table_value = '0;
  logic [31:0] x_value = '0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        done;
  logic [31:0] result;
  logic        in_range;
  int          fail_count, pending, lookups_seen;
  int          idle_pct = 0;
  int          items_sent = 0;
  int          loads_sent = 0;
  int          stall_cycles = 0;
  logic [31:0] knots [32];
  int          live_count = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lut_linear_interpolator_top dut (.*);
  lut_linear_interpolator_checker u_check (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(input logic m, input logic [4:0] idx, input logic [31:0] ax,
                      input logic [31:0] tv, input logic [31:0] x);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    point_index <= idx;
    axis_value <= ax;
    table_value <= tv;
    x_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (m == ModeLoad) loads_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_count(input logic [5:0] c);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_count = (c == 0) ? 1 : ((c > 32) ? 32 : c);
  endtask

  // Load all 32 slots with ascending (or wide-span / descending) x and random y.
  task automatic load_curve(input int shape);
    logic [31:0] x;
    logic [31:0] step;
    x = (shape == 2) ? 32'hFFFF_0000 : $urandom_range(1000);
    step = (shape == 1) ? 32'h07FF_FFFF : $urandom_range(1 << $urandom_range(26), 1);
    for (int i = 0; i < 32; i++) begin
      knots[i] = x;
      send(ModeLoad, i[4:0], x, $urandom, $urandom);
      if (shape == 2) x = x - $urandom_range(5000);
      else x = x + step + $urandom_range(3);
    end
  endtask

  task automatic random_lookup();
    int k;
    logic [31:0] x;
    k = $urandom_range(live_count - 1);
    case ($urandom_range(4))
      0: x = knots[k];
      1: x = knots[k] + $urandom_range(7);
      2: x = knots[k] - $urandom_range(7);
      3: x = $urandom;
      default: x = (k + 1 < 32) ? knots[k] + (knots[k+1] - knots[k]) / 2 : knots[k] + 1;
    endcase
    send(ModeLookup, 5'($urandom), $urandom, $urandom, x);
  endtask

  initial begin
    int counts [6] = '{32, 1, 2, 0, 63, 17};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme curve, clamps, exact hits, decreasing y, full span.
    send(ModeLoad, 5'd0, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    send(ModeLoad, 5'd1, 32'hFFFF_FFFF, 32'h0000_0000, '0);
    set_count(6'd2);
    send(ModeLookup, '0, '0, '0, 32'h0000_0000);
    send(ModeLookup, '1, '1, '1, 32'hFFFF_FFFF);
    send(ModeLookup, '0, '0, '0, 32'h0000_0001);
    send(ModeLookup, '0, '0, '0, 32'h8000_0000);
    send(ModeLookup, '0, '0, '0, 32'hFFFF_FFFE);
    send(ModeLoad, 5'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '0);
    send(ModeLoad, 5'd0, 32'h0000_0001, 32'h0000_0000, '0);
    send(ModeLookup, '0, '0, '0, 32'hFFFF_FFFF);
    send(ModeLookup, '0, '0, '0, 32'h0000_0001);
    send(ModeLookup, '0, '0, '0, 32'h5555_5555);
    send(ModeLookup, '0, '0, '0, 32'hAAAA_AAAA);
    settle();
    set_count(6'd1);
    send(ModeLookup, '0, '0, '0, 32'h0000_0002);
    send(ModeLookup, '0, '0, '0, 32'h0000_0000);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 82 : 18);
      load_curve(ph % 3);
      set_count(6'(counts[ph]));
      for (int j = 0; j < 65; j++) begin
        if ($urandom_range(19) == 0) send(ModeLoad, 5'($urandom), knots[0], $urandom, '0);
        else random_lookup();
      end
      settle();
    end

    $display("Sent %0d transactions (%0d loads); checked %0d lookup results.",
             items_sent, loads_sent, lookups_seen);
    $display("Covered point counts 0..63 incl. saturation, wide-span and descending axes.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
